// ===== rtl/ptm_pkg.sv =====
package ptm_pkg;

  localparam int unsigned CountBits    = 16;
  localparam int unsigned Channels     = 4;
  localparam int unsigned CtlBits      = 3;
  localparam int unsigned RegBits      = 16;
  localparam int unsigned PrescaleBits = 16;
  localparam int unsigned CtrlRegBits  = CtlBits * Channels;
  localparam int unsigned OutCountBits = 16;
  localparam int unsigned CfgAddrBits  = 3;
  localparam int unsigned CfgDataBits  = 16;
  localparam int unsigned InDataBits   = 8;
  localparam int unsigned OutDataBits  = 24;

  // bit positions of one channel's control field
  localparam int unsigned CtlIrqBit   = 0;
  localparam int unsigned CtlResetBit = 1;
  localparam int unsigned CtlStopBit  = 2;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_RUN    = 2'd2,
    REQ_STATUS = 2'd3
  } req_type_e;

  typedef enum logic [CfgAddrBits-1:0] {
    CFG_PRESCALE_LIMIT = 3'd0,
    CFG_MATCH_VALUE_0  = 3'd1,
    CFG_MATCH_VALUE_1  = 3'd2,
    CFG_MATCH_VALUE_2  = 3'd3,
    CFG_MATCH_VALUE_3  = 3'd4,
    CFG_MATCH_CONTROL  = 3'd5
  } cfg_addr_e;

  typedef struct packed {
    logic       count_clear;
    logic       run_enable;
    logic [3:0] clear_mask;
  } in_fields_t;

  typedef struct packed {
    logic                    running;
    logic                    irq;
    logic [Channels-1:0]     match_flags;
    logic [OutCountBits-1:0] count_value;
  } out_fields_t;

endpackage

// ===== rtl/prescaled_match_timer.sv =====
// Prescaled match timer: a 16-bit counter advanced by tick transactions on the
// slave stream, through a 16-bit prescaler, with four match channels that can
// set an interrupt flag, reset the count or stop the timer. Every slave
// transaction (tick, clear flags, run control, read status) returns exactly one
// status transaction on the master stream, valid in the cycle after acceptance.
// One transaction is taken per cycle unless the master side stalls; the state
// update and the match compare sit in a single combinational step between the
// state registers and the output register. While a result waits on the master
// side the slave side is held off; a new transaction is taken in the same cycle
// the waiting result leaves, so back-to-back transactions flow without gaps. The user
// must write match and prescale registers via the cfg port only while idle; unenforced.
module prescaled_match_timer
  import ptm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgAddrBits-1:0] cfg_addr_i,
  input  logic [CfgDataBits-1:0] cfg_data_i,

  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [3:0] clear_mask, [4] run_enable, [5] count_clear, [7:6] zero
  input  logic [InDataBits-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]             s_axis_tuser,

  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] count_value, [19:16] match_flags, [20] irq, [21] running, [23:22] zero
  output logic [OutDataBits-1:0] m_axis_tdata
);

  logic [PrescaleBits-1:0] prescale_limit_q;
  logic [RegBits-1:0]      match_value_q [Channels];
  logic [CtrlRegBits-1:0]  match_control_q;

  logic [CountBits-1:0]    main_count_q, main_count_d;
  logic [PrescaleBits-1:0] prescale_q, prescale_d;
  logic [Channels-1:0]     flags_q, flags_d;
  logic                    run_q, run_d;

  logic                    out_valid_q, out_valid_d;
  out_fields_t             out_q, out_d;

  logic                    s_accept;
  in_fields_t              in_f;
  req_type_e               req;

  logic [Channels-1:0]     hit_flags;
  logic                    hit_reset;
  logic                    hit_stop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_f          = in_fields_t'(s_axis_tdata[5:0]);
  assign req           = req_type_e'(s_axis_tuser);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_limit_q <= '0;
      match_control_q  <= '0;
      for (int c = 0; c < Channels; c++) begin
        match_value_q[c] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_PRESCALE_LIMIT: prescale_limit_q <= cfg_data_i[PrescaleBits-1:0];
        CFG_MATCH_VALUE_0:  match_value_q[0] <= cfg_data_i[RegBits-1:0];
        CFG_MATCH_VALUE_1:  match_value_q[1] <= cfg_data_i[RegBits-1:0];
        CFG_MATCH_VALUE_2:  match_value_q[2] <= cfg_data_i[RegBits-1:0];
        CFG_MATCH_VALUE_3:  match_value_q[3] <= cfg_data_i[RegBits-1:0];
        CFG_MATCH_CONTROL:  match_control_q  <= cfg_data_i[CtrlRegBits-1:0];
        default: ;
      endcase
    end
  end

  // match compare on the current count, per channel
  always_comb begin
    logic [CtlBits-1:0] ctl;
    hit_flags = '0;
    hit_reset = 1'b0;
    hit_stop  = 1'b0;
    for (int c = 0; c < Channels; c++) begin
      ctl = match_control_q[c*CtlBits +: CtlBits];
      if (CountBits'(match_value_q[c]) == main_count_q) begin
        hit_flags[c] = ctl[CtlIrqBit];
        hit_reset    = hit_reset | ctl[CtlResetBit];
        hit_stop     = hit_stop  | ctl[CtlStopBit];
      end
    end
  end

  always_comb begin
    main_count_d = main_count_q;
    prescale_d   = prescale_q;
    flags_d      = flags_q;
    run_d        = run_q;
    unique case (req)
      REQ_TICK: begin
        if (run_q) begin
          if (prescale_q == prescale_limit_q) begin
            prescale_d = '0;
            flags_d    = flags_q | hit_flags;
            if (hit_reset) begin
              main_count_d = '0;
            end else if (!hit_stop) begin
              main_count_d = main_count_q + CountBits'(1);
            end
            if (hit_stop) begin
              run_d = 1'b0;
            end
          end else begin
            prescale_d = prescale_q + PrescaleBits'(1);
          end
        end
      end
      REQ_CLEAR: begin
        flags_d = flags_q & ~in_f.clear_mask[Channels-1:0];
      end
      REQ_RUN: begin
        run_d = in_f.run_enable;
        if (in_f.count_clear) begin
          main_count_d = '0;
          prescale_d   = '0;
        end
      end
      REQ_STATUS: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_count_q <= '0;
      prescale_q   <= '0;
      flags_q      <= '0;
      run_q        <= 1'b0;
    end else if (s_accept) begin
      main_count_q <= main_count_d;
      prescale_q   <= prescale_d;
      flags_q      <= flags_d;
      run_q        <= run_d;
    end
  end

  // result register: load on accept, hold while the master side stalls
  always_comb begin
    out_d.count_value = main_count_d[OutCountBits-1:0];
    out_d.match_flags = flags_d;
    out_d.irq         = |flags_d;
    out_d.running     = run_d;
  end

  assign out_valid_d = s_accept || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q};

endmodule

// ===== rtl/ptm_checker.sv =====
module ptm_checker
  import ptm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [InDataBits-1:0]  s_axis_tdata,
  input logic [1:0]             s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OutDataBits-1:0] m_axis_tdata
);

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // every accepted transaction has its result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  // irq follows the pending flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[20] == (m_axis_tdata[19:16] != 4'd0)))
    else $error("irq does not match flags");

  // clearing every flag leaves none pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser == REQ_CLEAR && s_axis_tdata[3:0] == 4'hf)
      |=> (m_axis_tdata[19:16] == 4'd0 && !m_axis_tdata[20]))
    else $error("flags remain after full clear");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind prescaled_match_timer ptm_checker u_ptm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/tb_prescaled_match_timer.sv =====
`timescale 1ns / 100ps

module tb_prescaled_match_timer;
  import ptm_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned HoldAtResult  = 400;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned RandPhases    = 9;
  localparam int unsigned PhaseItems    = 100;

  localparam logic [CtlBits-1:0] CtlIrq   = CtlBits'(1 << CtlIrqBit);
  localparam logic [CtlBits-1:0] CtlReset = CtlBits'(1 << CtlResetBit);
  localparam logic [CtlBits-1:0] CtlStop  = CtlBits'(1 << CtlStopBit);

  typedef struct {
    req_type_e  kind;
    in_fields_t f;
  } timer_req_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgAddrBits-1:0] cfg_addr_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [InDataBits-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata;

  // timer state and register copies as the block should hold them
  logic [CountBits-1:0]    cur_count;
  logic [PrescaleBits-1:0] cur_prescale;
  logic [Channels-1:0]     cur_flags;
  logic                    cur_running;
  logic [PrescaleBits-1:0] cfg_limit;
  logic [CountBits-1:0]    cfg_match [Channels];
  logic [CtrlRegBits-1:0]  cfg_ctl;

  timer_req_t  pending_reqs [$];
  out_fields_t status_expected [$];
  timer_req_t  tx_item;
  int unsigned tx_gap;
  bit          tx_burst;
  int unsigned rx_stall;
  bit          rx_burst;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  out_fields_t mon_got;
  out_fields_t mon_want;

  prescaled_match_timer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic out_fields_t timer_update(input timer_req_t r);
    logic               step_reset;
    logic               step_stop;
    logic [CtlBits-1:0] ctl;
    out_fields_t        o;
    step_reset = 1'b0;
    step_stop  = 1'b0;
    case (r.kind)
      REQ_TICK: begin
        if (cur_running) begin
          if (cur_prescale == cfg_limit) begin
            cur_prescale = '0;
            for (int c = 0; c < Channels; c++) begin
              if (cfg_match[c] == cur_count) begin
                ctl = cfg_ctl[CtlBits*c +: CtlBits];
                if (ctl[CtlIrqBit]) cur_flags[c] = 1'b1;
                if (ctl[CtlResetBit]) step_reset = 1'b1;
                if (ctl[CtlStopBit]) step_stop = 1'b1;
              end
            end
            // a reset wins over a stop; a stop alone holds the count
            if (step_reset) cur_count = '0;
            else if (!step_stop) cur_count = cur_count + CountBits'(1);
            if (step_stop) cur_running = 1'b0;
          end else begin
            cur_prescale = cur_prescale + PrescaleBits'(1);
          end
        end
      end
      REQ_CLEAR: cur_flags = cur_flags & ~r.f.clear_mask;
      REQ_RUN: begin
        cur_running = r.f.run_enable;
        if (r.f.count_clear) begin
          cur_count    = '0;
          cur_prescale = '0;
        end
      end
      default: ;
    endcase
    o.count_value = cur_count;
    o.match_flags = cur_flags;
    o.irq         = |cur_flags;
    o.running     = cur_running;
    return o;
  endfunction

  function automatic timer_req_t make_req(input req_type_e kind, input logic clr,
                                          input logic en, input logic [3:0] mask);
    timer_req_t r;
    r.kind = kind;
    r.f.count_clear = clr;
    r.f.run_enable  = en;
    r.f.clear_mask  = mask;
    return r;
  endfunction

  function automatic timer_req_t random_request();
    timer_req_t  r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.f  = in_fields_t'($urandom_range(0, 63));
    if (pick < 70) r.kind = REQ_TICK;
    else if (pick < 80) r.kind = REQ_CLEAR;
    else if (pick < 90) begin
      r.kind = REQ_RUN;
      r.f.run_enable  = ($urandom_range(0, 4) != 0);
      r.f.count_clear = ($urandom_range(0, 3) == 0);
    end else r.kind = REQ_STATUS;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic write_reg(input logic [CfgAddrBits-1:0] idx,
                           input logic [CfgDataBits-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_PRESCALE_LIMIT: cfg_limit = val;
      CFG_MATCH_VALUE_0:  cfg_match[0] = val;
      CFG_MATCH_VALUE_1:  cfg_match[1] = val;
      CFG_MATCH_VALUE_2:  cfg_match[2] = val;
      CFG_MATCH_VALUE_3:  cfg_match[3] = val;
      CFG_MATCH_CONTROL:  cfg_ctl = val[CtrlRegBits-1:0];
      default: ;
    endcase
  endtask

  // sample on the falling edge so the queues and tvalid have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || status_expected.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) status_expected.push_back(timer_update(tx_item));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          tx_item = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= tx_item.kind;
          s_axis_tdata  <= InDataBits'(tx_item.f);
          if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got = out_fields_t'(m_axis_tdata[$bits(out_fields_t)-1:0]);
        if (status_expected.size() == 0) begin
          $display("%0t: unexpected status transaction %0h, none expected, got %0h",
                   $time, m_axis_tdata, m_axis_tdata);
          mismatch_count++;
        end else begin
          mon_want = status_expected.pop_front();
          check_field("count_value", mon_want.count_value, mon_got.count_value);
          check_field("match_flags", 16'(mon_want.match_flags), 16'(mon_got.match_flags));
          check_field("irq", 16'(mon_want.irq), 16'(mon_got.irq));
          check_field("running", 16'(mon_want.running), 16'(mon_got.running));
        end
        results_seen++;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_stall = rx_burst ? 0 : $urandom_range(0, 6);
        // hold off long enough for the block to back up into its input
        if (results_seen == HoldAtResult) rx_stall = HoldCycles;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    cur_count    = '0;
    cur_prescale = '0;
    cur_flags    = '0;
    cur_running  = 1'b0;
    cfg_limit    = '0;
    cfg_ctl      = '0;
    for (int c = 0; c < Channels; c++) cfg_match[c] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single interrupt at 1, stop alone at 2; ignored fields set high
    write_reg(CFG_PRESCALE_LIMIT, '0);
    write_reg(CFG_MATCH_VALUE_0, 16'd1);
    write_reg(CFG_MATCH_VALUE_1, 16'd3);
    write_reg(CFG_MATCH_VALUE_2, 16'd3);
    write_reg(CFG_MATCH_VALUE_3, 16'd2);
    write_reg(CFG_MATCH_CONTROL, {4'hF, CtlStop, CtlReset, CtlStop | CtlIrq, CtlIrq});
    pending_reqs.push_back(make_req(REQ_STATUS, 1'b1, 1'b1, 4'hF));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b1, 1'b1, 4'hF));
    pending_reqs.push_back(make_req(REQ_RUN, 1'b1, 1'b1, 4'hF));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_RUN, 1'b0, 1'b1, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b1, 1'b0, 4'h5));
    pending_reqs.push_back(make_req(REQ_CLEAR, 1'b1, 1'b1, 4'h1));
    pending_reqs.push_back(make_req(REQ_STATUS, 1'b0, 1'b0, 4'h0));
    wait_drained();

    // retire the stop-alone channel; reset and stop meet at 3
    write_reg(CFG_MATCH_VALUE_3, 16'hFFFF);
    pending_reqs.push_back(make_req(REQ_RUN, 1'b0, 1'b1, 4'hA));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_CLEAR, 1'b0, 1'b0, 4'hF));
    pending_reqs.push_back(make_req(REQ_RUN, 1'b1, 1'b0, 4'h0));
    wait_drained();

    // run the prescaler up, then drop the limit beneath it
    write_reg(CFG_PRESCALE_LIMIT, 16'd3);
    pending_reqs.push_back(make_req(REQ_RUN, 1'b1, 1'b1, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    wait_drained();
    write_reg(CFG_PRESCALE_LIMIT, '0);
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    pending_reqs.push_back(make_req(REQ_RUN, 1'b1, 1'b1, 4'h0));
    pending_reqs.push_back(make_req(REQ_TICK, 1'b0, 1'b0, 4'h0));
    wait_drained();

    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin
          write_reg(CFG_PRESCALE_LIMIT, 16'hFFFF);
          for (int c = 0; c < Channels; c++)
            write_reg(CfgAddrBits'(CFG_MATCH_VALUE_0) + CfgAddrBits'(c), 16'hFFFF);
          write_reg(CFG_MATCH_CONTROL, 16'hFFFF);
        end
        1: begin
          write_reg(CFG_PRESCALE_LIMIT, '0);
          for (int c = 0; c < Channels; c++)
            write_reg(CfgAddrBits'(CFG_MATCH_VALUE_0) + CfgAddrBits'(c), '0);
          write_reg(CFG_MATCH_CONTROL, '0);
          write_reg(CfgAddrBits'(CFG_MATCH_CONTROL) + CfgAddrBits'(1), 16'hFFFF);
          write_reg(CfgAddrBits'(CFG_MATCH_CONTROL) + CfgAddrBits'(2), 16'hFFFF);
        end
        default: begin
          write_reg(CFG_PRESCALE_LIMIT, CfgDataBits'(($urandom_range(0, 7) == 0) ?
                    $urandom_range(0, 16'hFFFF) : $urandom_range(0, 3)));
          for (int c = 0; c < Channels; c++)
            write_reg(CfgAddrBits'(CFG_MATCH_VALUE_0) + CfgAddrBits'(c),
                      CfgDataBits'(($urandom_range(0, 7) == 0) ?
                                   $urandom_range(0, 16'hFFFF) : $urandom_range(0, 15)));
          write_reg(CFG_MATCH_CONTROL, CfgDataBits'($urandom_range(0, 16'hFFFF)));
          write_reg(CfgAddrBits'(CFG_MATCH_CONTROL) + CfgAddrBits'($urandom_range(1, 2)),
                    CfgDataBits'($urandom_range(0, 16'hFFFF)));
        end
      endcase
      // mostly start from a clean count so the match channels get reached
      if (p < 2 || $urandom_range(0, 3) != 0)
        pending_reqs.push_back(make_req(REQ_RUN, 1'b1, 1'b1, 4'($urandom_range(0, 15))));
      for (int i = 0; i < ((p == 0) ? 30 : PhaseItems); i++)
        pending_reqs.push_back(random_request());
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
